### sv/lnps_pkg.sv
package lnps_pkg;

  // Number of notes the stack can hold.
  localparam int unsigned Depth = 10;

  // Widths of the stored state.
  localparam int unsigned NoteW  = 7;
  localparam int unsigned OpW    = 2;
  localparam int unsigned HeldW  = 4;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned IdxW   = (Depth > 1) ? $clog2(Depth) : 1;

  // Request opcodes.
  localparam logic [OpW-1:0] OpNoteOn  = 2'd0;
  localparam logic [OpW-1:0] OpNoteOff = 2'd1;
  localparam logic [OpW-1:0] OpClear   = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StPush,
    StDone
  } lnps_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic step;
    logic remove;
    logic push;
    logic clear;
    logic load_out;
  } lnps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            match;
    logic            last;
    logic            empty;
    logic            out_free;
    logic [OpW-1:0]  op;
  } lnps_status_t;

endpackage

### sv/lnps_ctrl.sv
module lnps_ctrl
  import lnps_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  lnps_status_t status_i,
  output lnps_cmd_t    cmd_o
);

  lnps_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StSearch;
        end
      end
      StSearch: begin
        // Walk the list from the newest entry looking for the request's note.
        priority if (status_i.op == OpClear) begin
          cmd_o.clear = 1'b1;
          state_d     = StDone;
        end else if (status_i.op != OpNoteOn && status_i.op != OpNoteOff) begin
          state_d = StDone;
        end else if (status_i.empty) begin
          state_d = (status_i.op == OpNoteOn) ? StPush : StDone;
        end else if (status_i.match) begin
          cmd_o.remove = 1'b1;
          state_d      = (status_i.op == OpNoteOn) ? StPush : StDone;
        end else if (status_i.last) begin
          state_d = (status_i.op == OpNoteOn) ? StPush : StDone;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StPush: begin
        cmd_o.push = 1'b1;
        state_d    = StDone;
      end
      StDone: begin
        // Hand the result over once the output register is free.
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

### sv/lnps_datapath.sv
module lnps_datapath
  import lnps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lnps_cmd_t        cmd_i,
  output lnps_status_t     status_o,
  input  logic [OpW-1:0]   opcode_i,
  input  logic [NoteW-1:0] note_number_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [NoteW-1:0] top_note_o,
  output logic             stack_empty_o,
  output logic [HeldW-1:0] held_count_o
);

  logic [NoteW-1:0] notes_q [Depth];
  logic [CntW-1:0]  count_q;
  logic [IdxW-1:0]  idx_q;
  logic [OpW-1:0]   op_q;
  logic [NoteW-1:0] note_q;
  logic             out_valid_q;
  logic [NoteW-1:0] top_note_q;
  logic             stack_empty_q;
  logic [HeldW-1:0] held_count_q;

  // Status for the controller.
  always_comb begin
    status_o.match    = (notes_q[idx_q] == note_q);
    status_o.last     = (CntW'(idx_q) == count_q - CntW'(1));
    status_o.empty    = (count_q == '0);
    status_o.out_free = !out_valid_q || !out_stall_i;
    status_o.op       = op_q;
  end

  // Request capture and search index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      note_q <= note_number_i;
      idx_q  <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // Held note count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.remove) begin
      count_q <= count_q - CntW'(1);
    end else if (cmd_i.push && count_q != CntW'(Depth)) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // Recency list: entry 0 is the newest. Removal closes the gap at the
  // search index; a push shifts every entry back and drops the oldest.
  always_ff @(posedge clk_i) begin
    if (cmd_i.remove) begin
      for (int i = 0; i < int'(Depth) - 1; i++) begin
        if (IdxW'(i) >= idx_q) begin
          notes_q[i] <= notes_q[i+1];
        end
      end
    end else if (cmd_i.push) begin
      for (int i = 1; i < int'(Depth); i++) begin
        notes_q[i] <= notes_q[i-1];
      end
      notes_q[0] <= note_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      top_note_q    <= (count_q != '0) ? notes_q[0] : '0;
      stack_empty_q <= (count_q == '0);
      held_count_q  <= HeldW'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_note_o    = top_note_q;
  assign stack_empty_o = stack_empty_q;
  assign held_count_o  = held_count_q;

endmodule

### sv/last_note_priority_stack_core.sv
// Last-note-priority note stack. Each request carries an opcode (note on,
// note off, clear) and a note number and yields one result: the most recent
// held note, an empty flag and the held count. A request is taken in, then
// the controller walks the recency list from the newest note, one entry per
// search step and at most Depth entries (ten by default), pushes the note
// for a note-on and loads the output register; the sequential search over
// the list sets how long a request lasts. The load waits while the previous
// result is still held by a stalled receiver. The input stalls while a
// request is in progress; a finished result waits in the output register
// while the next request is taken in.
module last_note_priority_stack_core
  import lnps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OpW-1:0]   opcode_i,
  input  logic [NoteW-1:0] note_number_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [NoteW-1:0] top_note_o,
  output logic             stack_empty_o,
  output logic [HeldW-1:0] held_count_o
);

  lnps_cmd_t    cmd;
  lnps_status_t status;

  // Sequencer.
  lnps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Note list, count and output register.
  lnps_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .opcode_i      (opcode_i),
    .note_number_i (note_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .top_note_o    (top_note_o),
    .stack_empty_o (stack_empty_o),
    .held_count_o  (held_count_o)
  );

endmodule

### sv/lnps_checker.sv
module lnps_checker
  import lnps_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [OpW-1:0]   opcode_i,
  input logic [NoteW-1:0] note_number_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [NoteW-1:0] top_note_o,
  input logic             stack_empty_o,
  input logic [HeldW-1:0] held_count_o
);

  // A stalled result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(top_note_o) &&
      $stable(stack_empty_o) && $stable(held_count_o))
    else $error("stalled result changed");

  // An empty stack reports no note and no count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stack_empty_o |-> top_note_o == '0 && held_count_o == '0)
    else $error("empty result carries a note or a count");

  // The count never exceeds the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(held_count_o) <= 32'(Depth))
    else $error("held count above depth");

  // After a request is taken the block is busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while the previous one is in progress");

endmodule

bind last_note_priority_stack_core lnps_checker u_lnps_checker (.*);
